/* hw/rtl/bale_pkg.sv */
`timescale 1ns / 1ps

package bale_pkg;

	// Default store depth in entries.
	localparam int DEPTH_DEF = 128;

	// Reset value of the capacity register.
	localparam logic [7:0] CAPACITY_RST = 8'd128;

	// Command codes.
	localparam logic [1:0] CMD_APPEND = 2'd0;
	localparam logic [1:0] CMD_INSERT = 2'd1;
	localparam logic [1:0] CMD_FIND   = 2'd2;
	localparam logic [1:0] CMD_REMOVE = 2'd3;

	// Status codes.
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_FULL     = 3'd1;
	localparam logic [2:0] ST_POSITION = 3'd2;
	localparam logic [2:0] ST_EMPTY    = 3'd3;
	localparam logic [2:0] ST_NOTFOUND = 3'd4;

	typedef struct packed {
		logic [1:0]         cmd;
		logic signed [31:0] value;
		logic [6:0]         position;
	} req_t;

	typedef struct packed {
		logic [2:0] status;
		logic [6:0] found_position;
		logic [7:0] entry_count;
	} rsp_t;

endpackage

/* hw/rtl/bounded_array_list_engine.sv */
`timescale 1ns / 1ps
// Append and remove-last register their result as the request is taken; it is shown in the next cycle.
// Insert moves the entries from the end down to the position up by one place, one entry moved per cycle
// through the store, then writes the value. Find reads one entry per cycle, comparing it in the cycle after its read.
// One request at a time; the next one is taken when the result is taken, or later.
// Reset (arst_n low, asynchronous) empties the list and sets capacity to 128; store is not cleared.
module bounded_array_list_engine #(
	parameter int DEPTH = bale_pkg::DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	// Capacity register write port.
	input  logic          cfg_wr_en,
	input  logic [7:0]    cfg_wr_data,
	// Request channel.
	input  logic          req_valid,
	output logic          req_ready,
	input  bale_pkg::req_t req,
	// Result channel.
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output bale_pkg::rsp_t rsp
);

	// Address width of the store and width of the count, which can reach DEPTH itself.
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW   = $clog2(DEPTH + 1);
	// Common width for comparing the count with the capacity and the position.
	localparam int CMPW = (CW > 8) ? CW : 8;

	// One-hot sequencer states.
	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_SHIFT  = 4'b0010,
		S_INS_WR = 4'b0100,
		S_FIND   = 4'b1000
	} state_t;

	state_t            state_q, state_d;
	logic [7:0]        cap_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     idx_q;       // Next store index to read during find; during shift the read is one below it.
	logic [31:0]       value_q;
	logic [AW-1:0]     pos_q;
	logic              pend_s1;     // A store read was issued in the previous cycle.
	logic [AW-1:0]     pend_idx_s1; // Index that read came from (shift: index to write).
	logic              rsp_valid_q;
	bale_pkg::rsp_t    rsp_q;

	// The store: one write port, one read port with registered read data.
	logic [31:0]       mem [DEPTH];
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [31:0]       mem_wdata;
	logic              mem_re;
	logic [AW-1:0]     mem_raddr;
	logic [31:0]       mem_rdata;

	logic              req_fire;
	logic              is_full;
	logic              pos_beyond;
	logic [CW-1:0]     idx_dec;
	logic              rsp_set;

	// A request is taken only while the sequencer is idle and the result
	// register is empty or being emptied in this cycle.
	assign req_ready = (state_q == S_IDLE) && (!rsp_valid_q || rsp_ready);
	assign req_fire  = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// The list is full when the count reaches the capacity or the store depth.
	assign is_full    = (CMPW'(count_q) >= CMPW'(cap_q)) || (count_q == CW'(DEPTH));
	assign pos_beyond = CMPW'(req.position) > CMPW'(count_q);
	assign idx_dec    = idx_q - CW'(1);

	// A result is posted for every request that needs no sequencer work (append, remove,
	// a refused insert), at the end of an insert, and when a find stops.
	assign rsp_set = (req_fire && (req.cmd == bale_pkg::CMD_APPEND ||
			req.cmd == bale_pkg::CMD_REMOVE ||
			(req.cmd == bale_pkg::CMD_INSERT && (is_full || pos_beyond)))) ||
		(state_q == S_INS_WR) ||
		(state_q == S_FIND && state_d == S_IDLE);

	// Store port control. A shift reads the entry below the target while the
	// previous read lands one place up, so the two never touch the same entry.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = count_q[AW-1:0];
		mem_wdata = req.value;
		mem_re    = 1'b0;
		mem_raddr = idx_q[AW-1:0];
		unique case (state_q)
			S_IDLE: begin
				if (req_fire && req.cmd == bale_pkg::CMD_APPEND && !is_full) begin
					mem_we = 1'b1;
				end
			end
			S_SHIFT: begin
				mem_we    = pend_s1;
				mem_waddr = pend_idx_s1;
				mem_wdata = mem_rdata;
				mem_re    = (idx_q[AW-1:0] != pos_q) || (idx_q == CW'(DEPTH));
				mem_raddr = idx_dec[AW-1:0];
			end
			S_INS_WR: begin
				mem_we    = 1'b1;
				mem_waddr = pos_q;
				mem_wdata = value_q;
			end
			S_FIND: begin
				mem_re = idx_q < count_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			mem_rdata <= mem[mem_raddr];
		end
	end

	// Capacity register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= bale_pkg::CAPACITY_RST;
		end else if (cfg_wr_en) begin
			cap_q <= cfg_wr_data;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_fire && req.cmd == bale_pkg::CMD_INSERT && !is_full && !pos_beyond) begin
					state_d = S_SHIFT;
				end else if (req_fire && req.cmd == bale_pkg::CMD_FIND) begin
					state_d = S_FIND;
				end
			end
			S_SHIFT: begin
				if (!mem_re) begin
					state_d = S_INS_WR;
				end
			end
			S_INS_WR: begin
				state_d = S_IDLE;
			end
			S_FIND: begin
				if (pend_s1 && mem_rdata == value_q) begin
					state_d = S_IDLE;
				end else if (!mem_re && !pend_s1) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Sequencer, count and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			pend_s1     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (rsp_set) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					pend_s1 <= 1'b0;
					if (req_fire) begin
						unique case (req.cmd)
							bale_pkg::CMD_APPEND: begin
								if (!is_full) begin
									count_q <= count_q + CW'(1);
								end
							end
							bale_pkg::CMD_INSERT: begin
								idx_q <= count_q;
							end
							bale_pkg::CMD_FIND: begin
								idx_q <= '0;
							end
							bale_pkg::CMD_REMOVE: begin
								if (count_q != '0) begin
									count_q <= count_q - CW'(1);
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_SHIFT: begin
					pend_s1 <= mem_re;
					if (mem_re) begin
						idx_q <= idx_dec;
					end
				end
				S_INS_WR: begin
					count_q <= count_q + CW'(1);
				end
				S_FIND: begin
					pend_s1 <= mem_re;
					if (mem_re) begin
						idx_q <= idx_q + CW'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Payload registers: latched request fields, read tracking, result fields.
	always_ff @(posedge clk) begin
		if (state_q == S_SHIFT) begin
			pend_idx_s1 <= idx_q[AW-1:0];
		end else begin
			pend_idx_s1 <= idx_q[AW-1:0];
		end
		if (req_fire) begin
			value_q <= req.value;
			pos_q   <= AW'(req.position);
		end
		if (state_q == S_IDLE && req_fire) begin
			rsp_q.found_position <= '0;
			unique case (req.cmd)
				bale_pkg::CMD_APPEND: begin
					rsp_q.status      <= is_full ? bale_pkg::ST_FULL : bale_pkg::ST_OK;
					rsp_q.entry_count <= is_full ? 8'(count_q) : 8'(count_q + CW'(1));
				end
				bale_pkg::CMD_INSERT: begin
					rsp_q.status      <= is_full ? bale_pkg::ST_FULL : bale_pkg::ST_POSITION;
					rsp_q.entry_count <= 8'(count_q);
				end
				bale_pkg::CMD_FIND: begin
					rsp_q.status      <= bale_pkg::ST_NOTFOUND;
					rsp_q.entry_count <= 8'(count_q);
				end
				bale_pkg::CMD_REMOVE: begin
					rsp_q.status      <= (count_q == '0) ? bale_pkg::ST_EMPTY : bale_pkg::ST_OK;
					rsp_q.entry_count <= (count_q == '0) ? 8'(count_q) : 8'(count_q - CW'(1));
				end
				default: begin
				end
			endcase
		end else if (state_q == S_INS_WR) begin
			rsp_q.status      <= bale_pkg::ST_OK;
			rsp_q.entry_count <= 8'(count_q + CW'(1));
		end else if (state_q == S_FIND && pend_s1 && mem_rdata == value_q) begin
			rsp_q.status         <= bale_pkg::ST_OK;
			rsp_q.found_position <= 7'(pend_idx_s1);
		end
	end

`ifndef SYNTHESIS
	// The count never exceeds the store depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("list count exceeds store depth");

	// A shift never walks below the insert position.
	a_shift_floor: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHIFT) |-> (idx_q >= CW'(pos_q)))
		else $error("shift index fell below insert position");

	// A new request is only taken with the sequencer idle.
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |-> (state_q == S_IDLE))
		else $error("request taken while busy");

	// An insert that moves entries raises the count by one when it completes.
	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INS_WR) |=> (count_q == $past(count_q) + CW'(1)))
		else $error("insert did not grow the list");

	// A finished find or insert always leaves a result waiting.
	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE && state_d == S_IDLE) |=> rsp_valid_q)
		else $error("multi-cycle request ended without a result");
`endif

endmodule
